// File: rtl/core/detection_anchor_grid_generator_macros.svh
// Assertion helpers used by the checker of the anchor grid generator.
`ifndef DETECTION_ANCHOR_GRID_GENERATOR_MACROS_SVH
`define DETECTION_ANCHOR_GRID_GENERATOR_MACROS_SVH

// Same-cycle implication, sampled on the rising clock, off during reset.
`define DAGG_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("anchor grid generator check failed");

// Next-cycle implication, sampled on the rising clock, off during reset.
`define DAGG_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("anchor grid generator check failed");

`endif

// File: rtl/core/dagg_pkg.sv
package dagg_pkg;

   localparam int LAYERS           = 3;
   localparam int MAX_RATIOS       = 4;
   localparam int SCALES_PER_LAYER = 4;

   localparam int IMG_W    = 13;
   localparam int STRIDE_W = 12;
   localparam int MAP_W    = 13;
   localparam int CTR_W    = 16;
   localparam int SIZE_W   = 20;
   localparam int RATIO_W  = 16;
   localparam int CNT_W    = 3;
   localparam int LAYER_W  = 2;
   localparam int IDX_W    = 2;
   localparam int POS_W    = 12;
   localparam int BS_W     = 10;

   localparam logic [SIZE_W-1:0] SIZE_MAX = '1;

   localparam int TBL_DEPTH = LAYERS * MAX_RATIOS * SCALES_PER_LAYER;
   localparam int TBL_AW    = LAYER_W + 2 * IDX_W;

   // anchor output buffer
   localparam int OBUF_DEPTH = 4;
   localparam int OBUF_AW    = $clog2(OBUF_DEPTH);

   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 64;

   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_WIDTH   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_HEIGHT  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_LAYER_STRIDES = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_RATIO_TABLE   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_RATIO_COUNT   = 3'd4;

   typedef struct packed {
      logic [LAYERS-1:0][MAP_W-1:0] w;
      logic [LAYERS-1:0][MAP_W-1:0] h;
   } map_sizes_type;

   typedef struct packed {
      logic              valid;
      logic [TBL_AW-1:0] addr;
      logic [SIZE_W-1:0] w;
      logic [SIZE_W-1:0] h;
   } tbl_write_type;

   typedef struct packed {
      logic               oog;
      logic [LAYER_W-1:0] layer;
      logic [CTR_W-1:0]   xc;
      logic [CTR_W-1:0]   yc;
   } cell_type;

   typedef struct packed {
      logic [CTR_W-1:0]  xc;
      logic [CTR_W-1:0]  yc;
      logic [SIZE_W-1:0] w;
      logic [SIZE_W-1:0] h;
      logic [IDX_W-1:0]  n;
      logic [IDX_W-1:0]  m;
      logic              oog;
      logic              last;
   } anchor_type;

   typedef enum logic [1:0] {FR_IDLE, FR_DIV, FR_PUSH} front_state_type;

   typedef enum logic [2:0] {
      SU_IDLE, SU_MAP_LOAD, SU_MAP_DIV, SU_SZ_MUL1,
      SU_SZ_MUL2, SU_SZ_DIV, SU_SZ_SQRT, SU_SZ_STORE
   } setup_state_type;

   // base size times scale for each layer and scale slot
   function automatic logic [BS_W-1:0] base_scale(input logic [LAYER_W-1:0] layer,
                                                 input logic [IDX_W-1:0] m);
      logic [BS_W-1:0] v;
      v = '0;
      case (layer)
         2'd0: begin
            case (m)
               2'd0: v = 10'd80;
               2'd1: v = 10'd40;
               2'd2: v = 10'd20;
               default: v = 10'd10;
            endcase
         end
         2'd1: begin
            case (m)
               2'd0: v = 10'd128;
               2'd1: v = 10'd64;
               2'd2: v = 10'd32;
               default: v = 10'd16;
            endcase
         end
         default: begin
            case (m)
               2'd0: v = 10'd512;
               2'd1: v = 10'd256;
               2'd2: v = 10'd128;
               default: v = 10'd64;
            endcase
         end
      endcase
      return v;
   endfunction

endpackage

// File: rtl/core/dagg_setup.sv
module dagg_setup import dagg_pkg::*; (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              restart,
   input  logic [IMG_W-1:0]                  image_width,
   input  logic [IMG_W-1:0]                  image_height,
   input  logic [LAYERS*STRIDE_W-1:0]        layer_strides,
   input  logic [MAX_RATIOS*RATIO_W-1:0]     ratio_table,
   output logic                              busy,
   output map_sizes_type                     map_sizes,
   output tbl_write_type                     tbl_wr
);

   setup_state_type state_ff, state_in;

   logic [2:0]         map_idx_ff, map_idx_in;
   logic [LAYER_W-1:0] lay_ff, lay_in;
   logic [IDX_W-1:0]   n_ff, n_in, m_ff, m_in;
   logic               phase_ff, phase_in;
   logic [5:0]         cnt_ff, cnt_in;

   logic [62:0] num_ff, num_in;
   logic [41:0] den_ff, den_in;
   logic [41:0] rem_ff, rem_in;
   logic [62:0] quo_ff, quo_in;
   logic [18:0] bs2_ff, bs2_in;
   logic [25:0] sq_ff, sq_in;
   logic [63:0] src_ff, src_in;
   logic [33:0] srem_ff, srem_in;
   logic [31:0] root_ff, root_in;
   logic [SIZE_W-1:0] w_hold_ff, w_hold_in;
   logic [LAYERS-1:0][MAP_W-1:0] map_w_ff, map_w_in, map_h_ff, map_h_in;

   logic [LAYER_W-1:0]  map_layer;
   logic [STRIDE_W-1:0] stride_raw, stride_eff;
   logic [IMG_W-1:0]    map_img, sz_img;
   logic [13:0]         map_dividend;
   logic [RATIO_W-1:0]  ratio;
   logic [BS_W-1:0]     bs;
   logic [41:0]         prod;
   logic [42:0]         rem_sh;
   logic                ge;
   logic [41:0]         rem_nx;
   logic [62:0]         quo_nx;
   logic [35:0]         s_sh;
   logic [33:0]         trial;
   logic                sge;
   logic [33:0]         srem_nx;
   logic [31:0]         root_nx;
   logic [SIZE_W-1:0]   size_sat;
   logic                sz_done;

   // operand selection
   always_comb begin
      map_layer    = map_idx_ff[2:1];
      stride_raw   = STRIDE_W'(layer_strides >> (STRIDE_W * map_layer));
      stride_eff   = (stride_raw == '0) ? STRIDE_W'(1) : stride_raw;
      map_img      = map_idx_ff[0] ? image_height : image_width;
      map_dividend = 14'(map_img) + 14'(stride_eff) - 14'd1;
      sz_img       = phase_ff ? image_height : image_width;
      ratio        = RATIO_W'(ratio_table >> (RATIO_W * n_ff));
      bs           = base_scale(lay_ff, m_ff);
      prod         = (phase_ff ? 26'(bs2_ff) : sq_ff) * ratio;
      size_sat     = (root_ff[31:SIZE_W] != '0) ? SIZE_MAX : root_ff[SIZE_W-1:0];
      sz_done      = (lay_ff == LAYER_W'(LAYERS - 1)) && (n_ff == '1) && (m_ff == '1);
   end

   // restoring divide, one quotient bit per cycle; a zero divisor gives all ones
   always_comb begin
      rem_sh = {rem_ff, num_ff[62]};
      ge     = rem_sh >= {1'b0, den_ff};
      rem_nx = ge ? 42'(rem_sh - {1'b0, den_ff}) : rem_sh[41:0];
      quo_nx = {quo_ff[61:0], ge};
   end

   // digit-by-digit square root, one root bit per cycle
   always_comb begin
      s_sh    = {srem_ff, src_ff[63:62]};
      trial   = {root_ff, 2'b01};
      sge     = s_sh >= {2'b00, trial};
      srem_nx = sge ? 34'(s_sh - {2'b00, trial}) : s_sh[33:0];
      root_nx = {root_ff[30:0], sge};
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         SU_IDLE:     state_in = SU_IDLE;
         SU_MAP_LOAD: state_in = SU_MAP_DIV;
         SU_MAP_DIV:  if (cnt_ff == '0) state_in = (map_idx_ff == 3'd5) ? SU_SZ_MUL1
                                                                     : SU_MAP_LOAD;
         SU_SZ_MUL1:  state_in = SU_SZ_MUL2;
         SU_SZ_MUL2:  state_in = SU_SZ_DIV;
         SU_SZ_DIV:   if (cnt_ff == '0) state_in = SU_SZ_SQRT;
         SU_SZ_SQRT:  if (cnt_ff == '0) state_in = SU_SZ_STORE;
         SU_SZ_STORE: state_in = (phase_ff && sz_done) ? SU_IDLE : SU_SZ_MUL1;
         default:     state_in = SU_IDLE;
      endcase
      if (restart) state_in = SU_MAP_LOAD;
   end

   // datapath
   always_comb begin
      map_idx_in = map_idx_ff;
      lay_in     = lay_ff;
      n_in       = n_ff;
      m_in       = m_ff;
      phase_in   = phase_ff;
      cnt_in     = cnt_ff;
      num_in     = num_ff;
      den_in     = den_ff;
      rem_in     = rem_ff;
      quo_in     = quo_ff;
      bs2_in     = bs2_ff;
      sq_in      = sq_ff;
      src_in     = src_ff;
      srem_in    = srem_ff;
      root_in    = root_ff;
      w_hold_in  = w_hold_ff;
      map_w_in   = map_w_ff;
      map_h_in   = map_h_ff;
      case (state_ff)
         SU_MAP_LOAD: begin
            num_in = 63'(map_dividend);
            den_in = 42'(stride_eff);
            rem_in = '0;
            cnt_in = 6'd62;
         end
         SU_MAP_DIV: begin
            num_in = {num_ff[61:0], 1'b0};
            rem_in = rem_nx;
            quo_in = quo_nx;
            cnt_in = cnt_ff - 6'd1;
            if (cnt_ff == '0) begin
               if (map_idx_ff[0]) map_h_in[map_layer] = quo_nx[MAP_W-1:0];
               else               map_w_in[map_layer] = quo_nx[MAP_W-1:0];
               map_idx_in = map_idx_ff + 3'd1;
               lay_in     = '0;
               n_in       = '0;
               m_in       = '0;
               phase_in   = 1'b0;
            end
         end
         SU_SZ_MUL1: begin
            bs2_in = 19'(bs * bs);
            sq_in  = sz_img * sz_img;
         end
         SU_SZ_MUL2: begin
            if (phase_ff) begin
               num_in = 63'({prod, 20'b0});
               den_in = 42'(sq_ff);
            end else begin
               num_in = {bs2_ff, 44'b0};
               den_in = prod;
            end
            rem_in = '0;
            cnt_in = 6'd62;
         end
         SU_SZ_DIV: begin
            num_in = {num_ff[61:0], 1'b0};
            rem_in = rem_nx;
            quo_in = quo_nx;
            cnt_in = cnt_ff - 6'd1;
            if (cnt_ff == '0) begin
               src_in  = {1'b0, quo_nx};
               srem_in = '0;
               root_in = '0;
               cnt_in  = 6'd31;
            end
         end
         SU_SZ_SQRT: begin
            src_in  = {src_ff[61:0], 2'b00};
            srem_in = srem_nx;
            root_in = root_nx;
            cnt_in  = cnt_ff - 6'd1;
         end
         SU_SZ_STORE: begin
            if (!phase_ff) begin
               w_hold_in = size_sat;
               phase_in  = 1'b1;
            end else begin
               phase_in = 1'b0;
               m_in     = m_ff + 2'd1;
               if (m_ff == '1) begin
                  n_in = n_ff + 2'd1;
                  if (n_ff == '1) lay_in = lay_ff + 2'd1;
               end
            end
         end
         default: begin
         end
      endcase
      if (restart) map_idx_in = '0;
   end

   // outputs
   always_comb begin
      busy         = (state_ff != SU_IDLE);
      tbl_wr.valid = (state_ff == SU_SZ_STORE) && phase_ff;
      tbl_wr.addr  = {lay_ff, n_ff, m_ff};
      tbl_wr.w     = w_hold_ff;
      tbl_wr.h     = size_sat;
      map_sizes.w  = map_w_ff;
      map_sizes.h  = map_h_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= SU_MAP_LOAD;
         map_idx_ff <= '0;
         lay_ff     <= '0;
         n_ff       <= '0;
         m_ff       <= '0;
         phase_ff   <= 1'b0;
         cnt_ff     <= '0;
      end else begin
         state_ff   <= state_in;
         map_idx_ff <= map_idx_in;
         lay_ff     <= lay_in;
         n_ff       <= n_in;
         m_ff       <= m_in;
         phase_ff   <= phase_in;
         cnt_ff     <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      num_ff    <= num_in;
      den_ff    <= den_in;
      rem_ff    <= rem_in;
      quo_ff    <= quo_in;
      bs2_ff    <= bs2_in;
      sq_ff     <= sq_in;
      src_ff    <= src_in;
      srem_ff   <= srem_in;
      root_ff   <= root_in;
      w_hold_ff <= w_hold_in;
      map_w_ff  <= map_w_in;
      map_h_ff  <= map_h_in;
   end

endmodule

// File: rtl/core/dagg_front.sv
module dagg_front import dagg_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_push,
   output logic               req_full,
   input  logic [LAYER_W-1:0] req_layer,
   input  logic [POS_W-1:0]   req_row,
   input  logic [POS_W-1:0]   req_col,
   input  logic               setup_busy,
   input  map_sizes_type      map_sizes,
   input  logic               q_full,
   output logic               q_push,
   output cell_type           q_data
);

   front_state_type state_ff, state_in;

   logic [3:0]         cnt_ff, cnt_in;
   logic               oog_ff, oog_in;
   logic [LAYER_W-1:0] layer_ff, layer_in;
   logic [13:0]        xd_ff, xd_in, yd_ff, yd_in;
   logic [13:0]        xr_ff, xr_in, yr_ff, yr_in;
   logic [17:0]        xlow_ff, xlow_in, ylow_ff, ylow_in;
   logic [17:0]        xq_ff, xq_in, yq_ff, yq_in;

   logic               accept;
   logic               layer_ok;
   logic [LAYER_W-1:0] lsel;
   logic [MAP_W-1:0]   mw, mh;
   logic [29:0]        xnum, ynum;
   logic [14:0]        xs1, xs2, ys1, ys2;

   // one restoring step: {quotient bit, new remainder}
   function automatic logic [14:0] div_step(input logic [13:0] r, input logic b,
                                            input logic [13:0] d);
      logic [14:0] t;
      t = {r, b};
      if (t >= {1'b0, d}) return {1'b1, 14'(t - {1'b0, d})};
      return {1'b0, t[13:0]};
   endfunction

   always_comb begin
      layer_ok = (req_layer < LAYER_W'(LAYERS));
      lsel     = layer_ok ? req_layer : '0;
      mw       = map_sizes.w[lsel];
      mh       = map_sizes.h[lsel];
      xnum     = 30'({req_col, 1'b1, 16'b0}) + 30'(mw);
      ynum     = 30'({req_row, 1'b1, 16'b0}) + 30'(mh);
      xs1      = div_step(xr_ff, xlow_ff[17], xd_ff);
      xs2      = div_step(xs1[13:0], xlow_ff[16], xd_ff);
      ys1      = div_step(yr_ff, ylow_ff[17], yd_ff);
      ys2      = div_step(ys1[13:0], ylow_ff[16], yd_ff);
   end

   // outputs
   always_comb begin
      req_full = setup_busy ||
                 !((state_ff == FR_IDLE) || ((state_ff == FR_PUSH) && !q_full));
      accept   = req_push && !req_full;
      q_push   = (state_ff == FR_PUSH) && !q_full;
      q_data.oog   = oog_ff;
      q_data.layer = layer_ff;
      q_data.xc    = oog_ff ? '0 : ((xq_ff[17:16] != '0) ? '1 : xq_ff[15:0]);
      q_data.yc    = oog_ff ? '0 : ((yq_ff[17:16] != '0) ? '1 : yq_ff[15:0]);
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         FR_IDLE: if (accept) state_in = FR_DIV;
         FR_DIV:  if (cnt_ff == '0) state_in = FR_PUSH;
         FR_PUSH: if (!q_full) state_in = accept ? FR_DIV : FR_IDLE;
         default: state_in = FR_IDLE;
      endcase
   end

   // datapath: two quotient bits per cycle on both centers
   always_comb begin
      cnt_in   = cnt_ff;
      oog_in   = oog_ff;
      layer_in = layer_ff;
      xd_in    = xd_ff;
      yd_in    = yd_ff;
      xr_in    = xr_ff;
      yr_in    = yr_ff;
      xlow_in  = xlow_ff;
      ylow_in  = ylow_ff;
      xq_in    = xq_ff;
      yq_in    = yq_ff;
      if (accept) begin
         cnt_in   = 4'd8;
         oog_in   = !layer_ok || (13'(req_row) >= mh) || (13'(req_col) >= mw);
         layer_in = req_layer;
         xd_in    = {mw, 1'b0};
         yd_in    = {mh, 1'b0};
         xr_in    = 14'(xnum[29:18]);
         yr_in    = 14'(ynum[29:18]);
         xlow_in  = xnum[17:0];
         ylow_in  = ynum[17:0];
      end else if (state_ff == FR_DIV) begin
         cnt_in  = cnt_ff - 4'd1;
         xr_in   = xs2[13:0];
         yr_in   = ys2[13:0];
         xq_in   = {xq_ff[15:0], xs1[14], xs2[14]};
         yq_in   = {yq_ff[15:0], ys1[14], ys2[14]};
         xlow_in = {xlow_ff[15:0], 2'b00};
         ylow_in = {ylow_ff[15:0], 2'b00};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= FR_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      oog_ff   <= oog_in;
      layer_ff <= layer_in;
      xd_ff    <= xd_in;
      yd_ff    <= yd_in;
      xr_ff    <= xr_in;
      yr_ff    <= yr_in;
      xlow_ff  <= xlow_in;
      ylow_ff  <= ylow_in;
      xq_ff    <= xq_in;
      yq_ff    <= yq_in;
   end

endmodule

// File: rtl/core/dagg_cell_queue.sv
module dagg_cell_queue import dagg_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     push,
   input  cell_type push_data,
   output logic     full,
   input  logic     pop,
   output cell_type pop_data,
   output logic     empty
);

   cell_type   q_ff [0:1];
   logic       wptr_ff, wptr_in, rptr_ff, rptr_in;
   logic [1:0] cnt_ff, cnt_in;
   logic       do_push, do_pop;

   always_comb begin
      full     = (cnt_ff == 2'd2);
      empty    = (cnt_ff == 2'd0);
      do_push  = push && !full;
      do_pop   = pop && !empty;
      wptr_in  = do_push ? !wptr_ff : wptr_ff;
      rptr_in  = do_pop ? !rptr_ff : rptr_ff;
      cnt_in   = cnt_ff + 2'(do_push) - 2'(do_pop);
      pop_data = q_ff[rptr_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff <= 1'b0;
         rptr_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         wptr_ff <= wptr_in;
         rptr_ff <= rptr_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) q_ff[wptr_ff] <= push_data;
   end

endmodule

// File: rtl/core/dagg_back.sv
module dagg_back import dagg_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              cell_valid,
   input  cell_type          cell_head,
   output logic              cell_pop,
   input  logic [CNT_W-1:0]  ratio_count,
   input  tbl_write_type     tbl_wr,
   input  logic              rsp_pop,
   output logic              rsp_empty,
   output logic [CTR_W-1:0]  rsp_x_center,
   output logic [CTR_W-1:0]  rsp_y_center,
   output logic [SIZE_W-1:0] rsp_box_width,
   output logic [SIZE_W-1:0] rsp_box_height,
   output logic [IDX_W-1:0]  rsp_ratio_index,
   output logic [IDX_W-1:0]  rsp_scale_index,
   output logic              rsp_out_of_grid,
   output logic              rsp_last
);

   logic [2*SIZE_W-1:0] tbl_mem [0:TBL_DEPTH-1];
   logic [2*SIZE_W-1:0] rd_data_ff;

   logic [IDX_W-1:0] n_ff, n_in, m_ff, m_in;
   logic             b_valid_ff, b_valid_in;
   cell_type         b_cell_ff;
   logic [IDX_W-1:0] b_n_ff, b_m_ff;
   logic             b_last_ff;

   anchor_type         obuf_ff [0:OBUF_DEPTH-1];
   logic [OBUF_AW-1:0] wptr_ff, wptr_in, rptr_ff, rptr_in;
   logic [OBUF_AW:0]   ocnt_ff, ocnt_in;

   logic [IDX_W-1:0]  nr_last;
   logic              issue, last_issue, rd_en, do_pop;
   logic [TBL_AW-1:0] rd_addr;
   anchor_type        landing, head;

   always_comb begin
      if (ratio_count == '0)                         nr_last = '0;
      else if (ratio_count > CNT_W'(MAX_RATIOS))     nr_last = IDX_W'(MAX_RATIOS - 1);
      else                                           nr_last = IDX_W'(ratio_count - 3'd1);
      // issue only while the output buffer has room for what is in flight
      issue      = cell_valid &&
                   ((ocnt_ff + (OBUF_AW+1)'(b_valid_ff)) < (OBUF_AW+1)'(OBUF_DEPTH));
      last_issue = cell_head.oog ||
                   ((n_ff == nr_last) && (m_ff == IDX_W'(SCALES_PER_LAYER - 1)));
      cell_pop   = issue && last_issue;
      rd_en      = issue && !cell_head.oog;
      rd_addr    = {cell_head.layer, n_ff, m_ff};
      n_in       = n_ff;
      m_in       = m_ff;
      if (issue) begin
         if (last_issue) begin
            n_in = '0;
            m_in = '0;
         end else if (m_ff == IDX_W'(SCALES_PER_LAYER - 1)) begin
            n_in = n_ff + 2'd1;
            m_in = '0;
         end else begin
            m_in = m_ff + 2'd1;
         end
      end
      b_valid_in = issue;
   end

   always_comb begin
      landing.xc   = b_cell_ff.xc;
      landing.yc   = b_cell_ff.yc;
      landing.w    = rd_data_ff[2*SIZE_W-1:SIZE_W];
      landing.h    = rd_data_ff[SIZE_W-1:0];
      landing.n    = b_n_ff;
      landing.m    = b_m_ff;
      landing.oog  = 1'b0;
      landing.last = b_last_ff;
      if (b_cell_ff.oog) begin
         landing      = '0;
         landing.oog  = 1'b1;
         landing.last = 1'b1;
      end
      do_pop  = rsp_pop && (ocnt_ff != '0);
      wptr_in = b_valid_ff ? wptr_ff + OBUF_AW'(1) : wptr_ff;
      rptr_in = do_pop ? rptr_ff + OBUF_AW'(1) : rptr_ff;
      ocnt_in = ocnt_ff + (OBUF_AW+1)'(b_valid_ff) - (OBUF_AW+1)'(do_pop);
      head    = obuf_ff[rptr_ff];
   end

   assign rsp_empty       = (ocnt_ff == '0);
   assign rsp_x_center    = head.xc;
   assign rsp_y_center    = head.yc;
   assign rsp_box_width   = head.w;
   assign rsp_box_height  = head.h;
   assign rsp_ratio_index = head.n;
   assign rsp_scale_index = head.m;
   assign rsp_out_of_grid = head.oog;
   assign rsp_last        = head.last;

   always_ff @(posedge clock) begin
      if (tbl_wr.valid) tbl_mem[tbl_wr.addr] <= {tbl_wr.w, tbl_wr.h};
      if (rd_en)        rd_data_ff <= tbl_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         n_ff       <= '0;
         m_ff       <= '0;
         b_valid_ff <= 1'b0;
         wptr_ff    <= '0;
         rptr_ff    <= '0;
         ocnt_ff    <= '0;
      end else begin
         n_ff       <= n_in;
         m_ff       <= m_in;
         b_valid_ff <= b_valid_in;
         wptr_ff    <= wptr_in;
         rptr_ff    <= rptr_in;
         ocnt_ff    <= ocnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (issue) begin
         b_cell_ff <= cell_head;
         b_n_ff    <= n_ff;
         b_m_ff    <= m_ff;
         b_last_ff <= last_issue;
      end
      if (b_valid_ff) obuf_ff[wptr_ff] <= landing;
   end

endmodule

// File: rtl/core/detection_anchor_grid_generator.sv
// Anchor grid generator: push one grid cell (layer, row, col) and pop its
// anchors, 4 x ratio_count words (a count of zero acts as one, above four as
// four), ratio outer and scale inner, the final one flagged last; a cell
// outside the layer's map or with a bad layer yields one word flagged
// out_of_grid. The front takes a new cell only once a two-bit-per-cycle
// divider has finished both centers and the cell is being handed over, and
// the back emits one anchor per cycle from a precomputed size table while the
// output buffer has room. After reset and after every register write, full
// stays high while a serial divider and square-root unit rebuild the map
// sizes and the 48-entry size table.
module detection_anchor_grid_generator import dagg_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   // cell input
   input  logic                  req_push,
   output logic                  req_full,
   input  logic [LAYER_W-1:0]    req_layer,
   input  logic [POS_W-1:0]      req_row,
   input  logic [POS_W-1:0]      req_col,
   // anchor output
   output logic                  rsp_empty,
   input  logic                  rsp_pop,
   output logic [CTR_W-1:0]      rsp_x_center,
   output logic [CTR_W-1:0]      rsp_y_center,
   output logic [SIZE_W-1:0]     rsp_box_width,
   output logic [SIZE_W-1:0]     rsp_box_height,
   output logic [IDX_W-1:0]      rsp_ratio_index,
   output logic [IDX_W-1:0]      rsp_scale_index,
   output logic                  rsp_out_of_grid,
   output logic                  rsp_last,
   // register writes
   input  logic                  csr_wr_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wr_data
);

   logic [IMG_W-1:0]              image_width_ff, image_width_in;
   logic [IMG_W-1:0]              image_height_ff, image_height_in;
   logic [LAYERS*STRIDE_W-1:0]    layer_strides_ff, layer_strides_in;
   logic [MAX_RATIOS*RATIO_W-1:0] ratio_table_ff, ratio_table_in;
   logic [CNT_W-1:0]              ratio_count_ff, ratio_count_in;

   logic          setup_busy;
   map_sizes_type map_sizes;
   tbl_write_type tbl_wr;
   logic          q_push, q_full, q_pop, q_empty;
   cell_type      q_in_data, q_out_data;

   // register decode; writes land only in the addressed register
   always_comb begin
      image_width_in   = image_width_ff;
      image_height_in  = image_height_ff;
      layer_strides_in = layer_strides_ff;
      ratio_table_in   = ratio_table_ff;
      ratio_count_in   = ratio_count_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            CSR_IMAGE_WIDTH:   image_width_in   = csr_wr_data[IMG_W-1:0];
            CSR_IMAGE_HEIGHT:  image_height_in  = csr_wr_data[IMG_W-1:0];
            CSR_LAYER_STRIDES: layer_strides_in = csr_wr_data[LAYERS*STRIDE_W-1:0];
            CSR_RATIO_TABLE:   ratio_table_in   = csr_wr_data[MAX_RATIOS*RATIO_W-1:0];
            CSR_RATIO_COUNT:   ratio_count_in   = csr_wr_data[CNT_W-1:0];
            default: begin
               // drop writes to unmapped indexes
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         image_width_ff   <= 13'd320;
         image_height_ff  <= 13'd320;
         layer_strides_ff <= {12'd32, 12'd16, 12'd8};
         ratio_table_ff   <= 64'd4096;
         ratio_count_ff   <= 3'd1;
      end else begin
         image_width_ff   <= image_width_in;
         image_height_ff  <= image_height_in;
         layer_strides_ff <= layer_strides_in;
         ratio_table_ff   <= ratio_table_in;
         ratio_count_ff   <= ratio_count_in;
      end
   end

   // rebuild derived tables on every register write
   dagg_setup u_setup (
      .clock         (clock),
      .reset         (reset),
      .restart       (csr_wr_en),
      .image_width   (image_width_ff),
      .image_height  (image_height_ff),
      .layer_strides (layer_strides_ff),
      .ratio_table   (ratio_table_ff),
      .busy          (setup_busy),
      .map_sizes     (map_sizes),
      .tbl_wr        (tbl_wr)
   );

   // grid check and center division
   dagg_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_push   (req_push),
      .req_full   (req_full),
      .req_layer  (req_layer),
      .req_row    (req_row),
      .req_col    (req_col),
      .setup_busy (setup_busy),
      .map_sizes  (map_sizes),
      .q_full     (q_full),
      .q_push     (q_push),
      .q_data     (q_in_data)
   );

   // hold classified cells between front and back
   dagg_cell_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_in_data),
      .full      (q_full),
      .pop       (q_pop),
      .pop_data  (q_out_data),
      .empty     (q_empty)
   );

   // anchor expansion and output buffering
   dagg_back u_back (
      .clock           (clock),
      .reset           (reset),
      .cell_valid      (!q_empty),
      .cell_head       (q_out_data),
      .cell_pop        (q_pop),
      .ratio_count     (ratio_count_ff),
      .tbl_wr          (tbl_wr),
      .rsp_pop         (rsp_pop),
      .rsp_empty       (rsp_empty),
      .rsp_x_center    (rsp_x_center),
      .rsp_y_center    (rsp_y_center),
      .rsp_box_width   (rsp_box_width),
      .rsp_box_height  (rsp_box_height),
      .rsp_ratio_index (rsp_ratio_index),
      .rsp_scale_index (rsp_scale_index),
      .rsp_out_of_grid (rsp_out_of_grid),
      .rsp_last        (rsp_last)
   );

endmodule

// File: rtl/core/dagg_checker.sv
`include "detection_anchor_grid_generator_macros.svh"

module dagg_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_empty,
   input logic        rsp_pop,
   input logic [15:0] rsp_x_center,
   input logic [19:0] rsp_box_width,
   input logic [19:0] rsp_box_height,
   input logic [1:0]  rsp_ratio_index,
   input logic [1:0]  rsp_scale_index,
   input logic        rsp_out_of_grid,
   input logic        rsp_last
);

   // a waiting word stays until popped
   `DAGG_ASSERT_NEXT(a_rsp_hold, clock, reset, !rsp_empty && !rsp_pop, !rsp_empty)
   `DAGG_ASSERT_NEXT(a_rsp_stable, clock, reset, !rsp_empty && !rsp_pop, $stable(rsp_x_center))
   // a rejected cell is a single, zeroed word
   `DAGG_ASSERT_NOW(a_oog_last, clock, reset, !rsp_empty && rsp_out_of_grid, rsp_last)
   `DAGG_ASSERT_NOW(a_oog_zero, clock, reset, !rsp_empty && rsp_out_of_grid, (rsp_box_width == 20'd0) && (rsp_box_height == 20'd0) && (rsp_ratio_index == 2'd0))
   // a cell always closes on the last scale
   `DAGG_ASSERT_NOW(a_last_scale, clock, reset, !rsp_empty && rsp_last && !rsp_out_of_grid, rsp_scale_index == 2'd3)

endmodule

bind detection_anchor_grid_generator dagg_checker u_checker (.*);

// File: tb/sv/tb_detection_anchor_grid_generator.sv
module tb_detection_anchor_grid_generator;
   import dagg_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   // Anchor prediction and the queue of anchors still owed by the block.
   class anchor_board;
      logic [IMG_W-1:0]      img_w, img_h;
      logic [35:0]           strides;
      logic [63:0]           ratios;
      logic [CNT_W-1:0]      n_ratios;
      anchor_type            owed[$];
      int                    errors;

      function void restore();
         img_w = 13'd320;
         img_h = 13'd320;
         strides = {12'd32, 12'd16, 12'd8};
         ratios = 64'h1000;
         n_ratios = 3'd1;
      endfunction

      function void set_reg(logic [CSR_IDX_W-1:0] idx, logic [63:0] v);
         case (idx)
            CSR_IMAGE_WIDTH:   img_w = v[IMG_W-1:0];
            CSR_IMAGE_HEIGHT:  img_h = v[IMG_W-1:0];
            CSR_LAYER_STRIDES: strides = v[35:0];
            CSR_RATIO_TABLE:   ratios = v;
            CSR_RATIO_COUNT:   n_ratios = v[CNT_W-1:0];
            default: ;
         endcase
      endfunction

      function bit [63:0] root(bit [63:0] v);
         bit [63:0] res, b;
         res = 0;
         b = 64'd1 << 62;
         while (b > v) b = b >> 2;
         while (b != 0) begin
            if (v >= res + b) begin
               v = v - (res + b);
               res = (res >> 1) + b;
            end else begin
               res = res >> 1;
            end
            b = b >> 2;
         end
         return res;
      endfunction

      function bit [63:0] stride_of(int l);
         bit [63:0] s;
         s = 64'((strides >> (12 * l)) & 36'hFFF);
         return (s == 0) ? 64'd1 : s;
      endfunction

      function bit [63:0] map_of(bit [63:0] img, bit [63:0] s);
         return (img + s - 1) / s;
      endfunction

      function bit [15:0] center(bit [63:0] idx, bit [63:0] n);
         bit [63:0] v;
         v = ((2 * idx + 1) * 65536 + n) / (2 * n);
         return (v > 64'hFFFF) ? 16'hFFFF : v[15:0];
      endfunction

      // Queue every anchor that an accepted cell owes.
      function void note_cell(logic [LAYER_W-1:0] l, logic [POS_W-1:0] r, logic [POS_W-1:0] c);
         bit [63:0] s, mw, mh, nr, rt, bs, num, q, w, h;
         int        scl[3][4];
         int        base[3];
         anchor_type a;
         scl = '{'{8, 4, 2, 1}, '{8, 4, 2, 1}, '{32, 16, 8, 4}};
         base = '{10, 16, 16};
         a = '0;
         a.oog = 1'b1;
         a.last = 1'b1;
         if (l >= LAYERS) begin
            owed = {owed, a};
            return;
         end
         s = stride_of(int'(l));
         mw = map_of(64'(img_w), s);
         mh = map_of(64'(img_h), s);
         if (r >= mh || c >= mw) begin
            owed = {owed, a};
            return;
         end
         nr = (n_ratios == 0) ? 64'd1 :
              (n_ratios > MAX_RATIOS) ? 64'(MAX_RATIOS) : 64'(n_ratios);
         for (int n = 0; n < nr; n++) begin
            rt = (ratios >> (16 * n)) & 64'hFFFF;
            for (int m = 0; m < SCALES_PER_LAYER; m++) begin
               bs = 64'(base[l] * scl[l][m]);
               if (rt == 0) begin
                  w = 64'(SIZE_MAX);
               end else begin
                  num = bs << 22;
                  q = (num * num) / (img_w * img_w * rt);
                  w = root(q);
                  if (w > SIZE_MAX) w = 64'(SIZE_MAX);
               end
               num = bs << 10;
               q = (num * num * rt) / (img_h * img_h);
               h = root(q);
               if (h > SIZE_MAX) h = 64'(SIZE_MAX);
               a.xc = center(64'(c), mw);
               a.yc = center(64'(r), mh);
               a.w = w[SIZE_W-1:0];
               a.h = h[SIZE_W-1:0];
               a.n = n[IDX_W-1:0];
               a.m = m[IDX_W-1:0];
               a.oog = 1'b0;
               a.last = (n + 1 == nr && m + 1 == SCALES_PER_LAYER);
               owed = {owed, a};
            end
         end
      endfunction

      task report(string what, logic [63:0] got, logic [63:0] want);
         $display("mismatch %s: got %0h, want %0h", what, got, want);
         errors++;
      endtask

      task field(string what, logic [63:0] got, logic [63:0] want);
         if (got !== want) report(what, got, want);
      endtask

      task check_anchor(anchor_type got);
         anchor_type w;
         if (owed.size() == 0) begin
            report("unexpected word", 64'(got.xc), 64'd0);
            return;
         end
         w = owed.pop_front();
         field("x_center", 64'(got.xc), 64'(w.xc));
         field("y_center", 64'(got.yc), 64'(w.yc));
         field("box_width", 64'(got.w), 64'(w.w));
         field("box_height", 64'(got.h), 64'(w.h));
         field("ratio_index", 64'(got.n), 64'(w.n));
         field("scale_index", 64'(got.m), 64'(w.m));
         field("out_of_grid", 64'(got.oog), 64'(w.oog));
         field("last", 64'(got.last), 64'(w.last));
      endtask
   endclass

   localparam int LIMIT = 3000000;

   logic                  clock = 0;
   logic                  reset = 1;
   logic                  req_push = 0;
   logic                  req_full;
   logic [LAYER_W-1:0]    req_layer = '0;
   logic [POS_W-1:0]      req_row = '0;
   logic [POS_W-1:0]      req_col = '0;
   logic                  rsp_empty;
   logic                  rsp_pop = 0;
   logic [CTR_W-1:0]      rsp_x_center, rsp_y_center;
   logic [SIZE_W-1:0]     rsp_box_width, rsp_box_height;
   logic [IDX_W-1:0]      rsp_ratio_index, rsp_scale_index;
   logic                  rsp_out_of_grid, rsp_last;
   logic                  csr_wr_en = 0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wr_data = '0;

   anchor_board board = new();
   bit          rx_hold = 0;   // raised by the sender, cleared by the receiver
   bit          no_gaps = 0;   // stretch with no idling on either side
   int          cycles = 0;

   detection_anchor_grid_generator dut (.*);

   always begin
      #4 clock = 1;
      #4 clock = 0;
   end

   // Pick an idle length: mostly none or short, now and then long.
   function automatic int pick_gap();
      int r;
      if (no_gaps) return 0;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // Sample both handshakes at the rising edge; drivers move on the falling one.
   always @(posedge clock) begin
      anchor_type got;
      cycles++;
      if (cycles > LIMIT) begin
         $display("tb_detection_anchor_grid_generator NOT OK");
         $finish;
      end
      if (!reset && req_push && !req_full) board.note_cell(req_layer, req_row, req_col);
      if (!reset && rsp_pop && !rsp_empty) begin
         got.xc = rsp_x_center;
         got.yc = rsp_y_center;
         got.w = rsp_box_width;
         got.h = rsp_box_height;
         got.n = rsp_ratio_index;
         got.m = rsp_scale_index;
         got.oog = rsp_out_of_grid;
         got.last = rsp_last;
         board.check_anchor(got);
      end
   end

   // Receiver: random pop stalls, plus one long hold-off on request.
   always begin
      int stall;
      stall = 0;
      forever begin
         @(negedge clock);
         if (rx_hold) begin
            rsp_pop <= 0;
            repeat (400) @(negedge clock);
            rx_hold = 0;
         end else if (stall > 0) begin
            rsp_pop <= 0;
            stall--;
         end else begin
            rsp_pop <= 1;
            stall = pick_gap();
         end
      end
   end

   // Offer one cell and hold it until taken; then idle or keep push high.
   task automatic send_cell(logic [LAYER_W-1:0] l, logic [POS_W-1:0] r, logic [POS_W-1:0] c);
      int gap;
      @(negedge clock);
      req_push <= 1;
      req_layer <= l;
      req_row <= r;
      req_col <= c;
      do @(posedge clock); while (req_full);
      gap = pick_gap();
      if (gap > 0) begin
         @(negedge clock);
         req_push <= 0;
         repeat (gap - 1) @(negedge clock);
      end
   endtask

   task automatic drain();
      @(negedge clock);
      req_push <= 0;
      while (board.owed.size() != 0) @(posedge clock);
      repeat (30) @(posedge clock);
   endtask

   task automatic csr_write(logic [CSR_IDX_W-1:0] idx, logic [63:0] v);
      @(negedge clock);
      csr_wr_en <= 1;
      csr_index <= idx;
      csr_wr_data <= v;
      board.set_reg(idx, v);
   endtask

   task automatic csr_done();
      @(negedge clock);
      csr_wr_en <= 0;
   endtask

   // Random cell: mostly inside the current grid, some outside, some bad layer.
   task automatic random_cell();
      int        r;
      logic [1:0] l;
      bit [63:0] s, mw, mh;
      r = $urandom_range(0, 99);
      l = 2'($urandom_range(0, 2));
      s = board.stride_of(int'(l));
      mw = board.map_of(64'(board.img_w), s);
      mh = board.map_of(64'(board.img_h), s);
      if (r < 6) begin
         send_cell(2'd3, 12'($urandom), 12'($urandom));
      end else if (r < 16 || mw == 0 || mh == 0) begin
         send_cell(l, 12'($urandom), 12'($urandom));
      end else begin
         send_cell(l, 12'($urandom_range(0, 32'(mh > 4096 ? 4095 : mh - 1))),
                   12'($urandom_range(0, 32'(mw > 4096 ? 4095 : mw - 1))));
      end
   endtask

   initial begin
      board.restore();
      board.errors = 0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 0;

      // Reset settings: corners of every layer, map edges, bad layer.
      send_cell(2'd0, 12'd0, 12'd0);
      send_cell(2'd0, 12'd39, 12'd39);
      send_cell(2'd0, 12'd40, 12'd0);
      send_cell(2'd0, 12'd0, 12'd40);
      send_cell(2'd1, 12'd19, 12'd0);
      send_cell(2'd1, 12'd20, 12'd20);
      send_cell(2'd2, 12'd9, 12'd9);
      send_cell(2'd2, 12'd10, 12'd3);
      send_cell(2'd3, 12'd0, 12'd0);
      send_cell(2'd3, 12'hFFF, 12'hFFF);
      send_cell(2'd2, 12'hFFF, 12'hFFF);
      drain();

      // Image of 4096, stride one and largest stride, zero stride, mixed ratios.
      // Hold the receiver off while cells keep coming so the block backs up.
      csr_write(CSR_IMAGE_WIDTH, 64'd4096);
      csr_write(CSR_IMAGE_HEIGHT, 64'd4096);
      csr_write(CSR_LAYER_STRIDES, {28'd0, 12'd0, 12'hFFF, 12'd1});
      csr_write(CSR_RATIO_TABLE, {16'h0800, 16'hFFFF, 16'h0000, 16'h1000});
      csr_write(CSR_RATIO_COUNT, 64'd4);
      csr_done();
      send_cell(2'd0, 12'hFFF, 12'hFFF);
      send_cell(2'd0, 12'h000, 12'hFFF);
      send_cell(2'd1, 12'd0, 12'd0);
      send_cell(2'd1, 12'd1, 12'd0);
      send_cell(2'd2, 12'hFFF, 12'h800);
      rx_hold = 1;
      no_gaps = 1;
      repeat (25) random_cell();
      no_gaps = 0;
      repeat (15) random_cell();
      drain();

      // One-pixel image, all-ones strides, ratio count zero.
      csr_write(CSR_IMAGE_WIDTH, 64'd1);
      csr_write(CSR_IMAGE_HEIGHT, 64'd1);
      csr_write(CSR_LAYER_STRIDES, 64'hF_FFFF_FFFF);
      csr_write(CSR_RATIO_TABLE, {$urandom, $urandom});
      csr_write(CSR_RATIO_COUNT, 64'd0);
      csr_done();
      send_cell(2'd0, 12'd0, 12'd0);
      send_cell(2'd2, 12'd0, 12'd1);
      repeat (20) random_cell();
      drain();

      // Zero image size and ratio count above the limit.
      csr_write(CSR_IMAGE_WIDTH, 64'd0);
      csr_write(CSR_IMAGE_HEIGHT, 64'd0);
      csr_write(CSR_RATIO_COUNT, 64'd7);
      csr_done();
      send_cell(2'd0, 12'd0, 12'd0);
      repeat (8) random_cell();
      drain();

      // Random settings; pause mid-phase until every anchor is back.
      for (int p = 0; p < 3; p++) begin
         csr_write(CSR_IMAGE_WIDTH, 64'($urandom_range(1, 4096)));
         csr_write(CSR_IMAGE_HEIGHT, 64'($urandom_range(1, 4096)));
         csr_write(CSR_LAYER_STRIDES, 64'({12'($urandom_range(1, 128)),
                   12'($urandom_range(1, 64)), 12'($urandom_range(1, 32))}));
         csr_write(CSR_RATIO_TABLE, {$urandom, $urandom});
         csr_write(CSR_RATIO_COUNT, 64'($urandom_range(1, 4)));
         csr_done();
         repeat (15) random_cell();
         @(negedge clock);
         req_push <= 0;
         while (board.owed.size() != 0) @(posedge clock);
         repeat (20) random_cell();
         drain();
      end

      repeat (50) @(posedge clock);
      if (board.errors == 0 && board.owed.size() == 0) begin
         $display("tb_detection_anchor_grid_generator OK");
      end else begin
         $display("tb_detection_anchor_grid_generator NOT OK");
      end
      $finish;
   end

endmodule

// File: detection_anchor_grid_generator.f
+incdir+rtl/core
rtl/core/dagg_pkg.sv
rtl/core/dagg_setup.sv
rtl/core/dagg_front.sv
rtl/core/dagg_cell_queue.sv
rtl/core/dagg_back.sv
rtl/core/detection_anchor_grid_generator.sv
rtl/core/dagg_checker.sv
tb/sv/tb_detection_anchor_grid_generator.sv
